@@ rtl/ts_packet_header_parser_top_defines.svh @@
// assertion macros for the checker file of the header parser
// no dependencies; each macro expects clk in scope, the first two also rst_n
`ifndef TS_PACKET_HEADER_PARSER_TOP_DEFINES_SVH
`define TS_PACKET_HEADER_PARSER_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define TSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define TSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers the reset cycles
`define TSP_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tsp_pkg.sv @@
// constants shared by the transport stream header parser
// no dependencies
package tsp_pkg;

  localparam int SIZE_W     = 10;
  localparam int POS_W      = 48;
  localparam int HDR_W      = 24;
  localparam int ID_W       = 13;
  localparam int ID_COUNT   = 8192;
  localparam int OUT_CNT_W  = 32;

  localparam logic [7:0]        SYNC_VAL   = 8'h47;
  localparam logic [SIZE_W-1:0] MIN_SIZE   = 10'd4;
  localparam logic [SIZE_W-1:0] RESET_SIZE = 10'd188;
  localparam logic [SIZE_W-1:0] HDR_FIRST  = 10'd1;
  localparam logic [SIZE_W-1:0] HDR_LAST   = 10'd3;
  localparam logic [ID_W-1:0]   ID_LAST    = 13'(ID_COUNT - 1);

endpackage

@@ rtl/tsp_if.sv @@
// valid/ready channel interfaces for the byte input and the header result
// depends on tsp_pkg
interface tsp_in_if;
  import tsp_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
  modport mon    (input valid, input data_byte, input ready);
endinterface

interface tsp_out_if;
  import tsp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [POS_W-1:0]     packet_offset;
  logic                 error_flag;
  logic                 unit_start;
  logic                 priority_flag;
  logic [ID_W-1:0]      stream_id;
  logic [1:0]           scrambling;
  logic [1:0]           adaptation_mode;
  logic [3:0]           continuity;
  logic [OUT_CNT_W-1:0] id_packet_count;

  modport source (output valid, output packet_offset, output error_flag, output unit_start,
                  output priority_flag, output stream_id, output scrambling,
                  output adaptation_mode, output continuity, output id_packet_count,
                  input ready);
  modport sink   (input valid, input packet_offset, input error_flag, input unit_start,
                  input priority_flag, input stream_id, input scrambling,
                  input adaptation_mode, input continuity, input id_packet_count,
                  output ready);
  modport mon    (input valid, input packet_offset, input error_flag, input unit_start,
                  input priority_flag, input stream_id, input scrambling,
                  input adaptation_mode, input continuity, input id_packet_count,
                  input ready);
endinterface

@@ rtl/ts_packet_header_parser_top.sv @@
// transport stream packet header parser, top level
// depends on tsp_pkg, tsp_if and tsp_count_ram
//
// in_ch takes one stream byte per transfer; a byte other than 0x47 is
// skipped while hunting, a 0x47 opens a packet of the configured size
// (values below 4 act as 4). cfg_we/cfg_wdata write the packet size.
// out_ch carries one result per completed packet: sync byte offset,
// decoded header fields and the identifier's saturating packet count.
// throughput: one byte per cycle while in_ch.ready is high. the last byte
// of a packet issues a read of the counter memory into the memory stage;
// when that stage moves on, the count is incremented, written back and
// loaded into the output register, which then holds the valid result.
// packets end at least 4 transfers apart, so the write-back always lands
// before the next read of the memory.
// reset: a clearing pass writes zero to all 8192 counters, one per cycle;
// in_ch.ready stays low until the pass is done, cfg writes are taken.
// stall: the output register holds a result until taken while the next
// result waits in the memory stage; in_ch.ready drops, outside the
// clearing pass, only while that stage is full and the output cannot drain.
module ts_packet_header_parser_top #(
  parameter int COUNT_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tsp_in_if.sink                     in_ch,
  tsp_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [tsp_pkg::SIZE_W-1:0] cfg_wdata
);
  import tsp_pkg::*;

  localparam int CMP_W = SIZE_W + 1;

  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] size_eff;
  logic              in_packet_r;
  logic [SIZE_W-1:0] byte_idx_r;
  logic [SIZE_W-1:0] idx_nxt;
  logic [HDR_W-1:0]  hdr_r;
  logic [HDR_W-1:0]  hdr_nxt;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  start_r;

  logic              clr_r;
  logic [ID_W-1:0]   clr_addr_r;

  logic              p1_valid_r;
  logic [POS_W-1:0]  p1_offset_r;
  logic [HDR_W-1:0]  p1_hdr_r;
  logic              p1_move;
  logic              p1_stall;

  logic                 out_valid_r;
  logic [POS_W-1:0]     out_offset_r;
  logic [HDR_W-1:0]     out_hdr_r;
  logic [OUT_CNT_W-1:0] out_cnt_r;

  logic                  in_ready;
  logic                  in_xfer;
  logic                  pkt_end;
  logic                  ram_we;
  logic [ID_W-1:0]       ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [OUT_CNT_W-1:0]  cnt_out;

  // parser front end
  always_comb begin
    size_eff = (size_r < MIN_SIZE) ? MIN_SIZE : size_r;
    idx_nxt  = byte_idx_r + 1'b1;
    hdr_nxt  = hdr_r;
    if (idx_nxt >= HDR_FIRST && idx_nxt <= HDR_LAST) begin
      hdr_nxt = {hdr_r[HDR_W-9:0], in_ch.data_byte};
    end
  end

  assign p1_move  = p1_valid_r && (!out_valid_r || out_ch.ready);
  assign p1_stall = p1_valid_r && !p1_move;
  assign in_ready = !clr_r && !p1_stall;
  assign in_xfer  = in_ch.valid && in_ready;
  assign pkt_end  = in_xfer && in_packet_r &&
                    ({1'b0, idx_nxt} + CMP_W'(1) >= {1'b0, size_eff});

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= RESET_SIZE;
      in_packet_r <= 1'b0;
      byte_idx_r  <= '0;
      hdr_r       <= '0;
      pos_r       <= '0;
      start_r     <= '0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      if (in_xfer) begin
        pos_r <= pos_r + 1'b1;
        if (!in_packet_r) begin
          if (in_ch.data_byte == SYNC_VAL) begin
            in_packet_r <= 1'b1;
            byte_idx_r  <= '0;
            hdr_r       <= '0;
            start_r     <= pos_r;
          end
        end else begin
          byte_idx_r <= idx_nxt;
          hdr_r      <= hdr_nxt;
          if (pkt_end) begin
            in_packet_r <= 1'b0;
          end
        end
      end
    end
  end

  // clearing pass over the counter memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ID_LAST) begin
        clr_r <= 1'b0;
      end
    end
  end

  // memory stage: count read issued at packet end, written back when it moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (pkt_end) begin
      p1_valid_r <= 1'b1;
    end else if (p1_move) begin
      p1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_end) begin
      p1_offset_r <= start_r;
      p1_hdr_r    <= hdr_nxt;
    end
  end

  assign cnt_new   = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
  assign ram_we    = clr_r || p1_move;
  assign ram_waddr = clr_r ? clr_addr_r : p1_hdr_r[HDR_W-4 -: ID_W];
  assign ram_wdata = clr_r ? '0 : cnt_new;

  generate
    if (COUNT_BITS >= OUT_CNT_W) begin : g_cnt_trunc
      assign cnt_out = cnt_new[OUT_CNT_W-1:0];
    end else begin : g_cnt_ext
      assign cnt_out = {{(OUT_CNT_W - COUNT_BITS){1'b0}}, cnt_new};
    end
  endgenerate

  tsp_count_ram #(
    .DATA_W (COUNT_BITS)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (pkt_end),
    .rd_addr (hdr_nxt[HDR_W-4 -: ID_W]),
    .rd_data (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      out_offset_r <= p1_offset_r;
      out_hdr_r    <= p1_hdr_r;
      out_cnt_r    <= cnt_out;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.packet_offset   = out_offset_r;
  assign out_ch.error_flag      = out_hdr_r[23];
  assign out_ch.unit_start      = out_hdr_r[22];
  assign out_ch.priority_flag   = out_hdr_r[21];
  assign out_ch.stream_id       = out_hdr_r[20:8];
  assign out_ch.scrambling      = out_hdr_r[7:6];
  assign out_ch.adaptation_mode = out_hdr_r[5:4];
  assign out_ch.continuity      = out_hdr_r[3:0];
  assign out_ch.id_packet_count = out_cnt_r;

endmodule

@@ rtl/tsp_count_ram.sv @@
// per-identifier packet counter memory, one write and one registered read port
// depends on tsp_pkg
module tsp_count_ram #(
  parameter int DATA_W = 32
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [tsp_pkg::ID_W-1:0] wr_addr,
  input  logic [DATA_W-1:0]       wr_data,
  input  logic                    rd_en,
  input  logic [tsp_pkg::ID_W-1:0] rd_addr,
  output logic [DATA_W-1:0]       rd_data
);
  import tsp_pkg::*;

  logic [DATA_W-1:0] mem [ID_COUNT];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/tsp_checker.sv @@
// port-level checks for the header parser top level, with its bind
// depends on tsp_pkg and ts_packet_header_parser_top_defines.svh
`include "ts_packet_header_parser_top_defines.svh"

module tsp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tsp_pkg::POS_W-1:0]     out_offset,
  input logic [tsp_pkg::OUT_CNT_W-1:0] out_count
);

  logic stalled;

  assign stalled = out_valid && !out_ready;

  `TSP_ASSERT_NEXT(a_out_hold, stalled, out_valid, "result dropped while stalled")
  `TSP_ASSERT_NEXT(a_out_stable, stalled, $stable({out_offset, out_count}), "stalled result changed")
  `TSP_ASSERT_NOW(a_count_nonzero, out_valid, out_count != 0, "result count not incremented")
  `TSP_ASSERT_RST(a_clear_blocks, !rst_n, !in_ready, "input taken during counter clearing")

endmodule

bind ts_packet_header_parser_top tsp_checker u_tsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_offset (out_ch.packet_offset),
  .out_count  (out_ch.id_packet_count)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// testbench for ts_packet_header_parser_top: byte stream in, packet headers out
// depends on tsp_pkg, tsp_in_if/tsp_out_if and the parser rtl
// a scoreboard class predicts each header result and checks it in order
module tb;
  import tsp_pkg::*;

  localparam int QUIET_LIMIT  = 40000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int MAX_REPORTS  = 40;
  localparam logic [SIZE_W-1:0] PHASE_SIZES [16] = '{
    10'd8, 10'd3, 10'd17, 10'd1023, 10'd5, 10'd188, 10'd0, 10'd12,
    10'd6, 10'd30, 10'd2, 10'd9, 10'd64, 10'd4, 10'd11, 10'd8
  };

  typedef struct {
    logic [POS_W-1:0]     packet_offset;
    logic                 error_flag;
    logic                 unit_start;
    logic                 priority_flag;
    logic [ID_W-1:0]      stream_id;
    logic [1:0]           scrambling;
    logic [1:0]           adaptation_mode;
    logic [3:0]           continuity;
    logic [OUT_CNT_W-1:0] id_packet_count;
  } hdr_result_t;

  class header_scoreboard;
    bit [SIZE_W-1:0]    pkt_size;
    bit                 in_pkt;
    bit [SIZE_W-1:0]    idx;
    bit [HDR_W-1:0]     hdr;
    bit [POS_W-1:0]     pos;
    bit [POS_W-1:0]     start_pos;
    bit [OUT_CNT_W-1:0] id_count [ID_COUNT];
    hdr_result_t        header_q[$];
    int                 errors;
    int                 checked;

    function new();
      pkt_size = RESET_SIZE;
      in_pkt   = 1'b0;
      idx      = '0;
      hdr      = '0;
      pos      = '0;
      start_pos = '0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void write_size(logic [SIZE_W-1:0] v);
      pkt_size = v;
    endfunction

    function int pending();
      return header_q.size();
    endfunction

    function void note_byte(logic [7:0] b);
      bit [POS_W-1:0] here;
      bit [ID_W-1:0]  id;
      int             eff;
      hdr_result_t    r;
      here = pos;
      pos  = pos + 1'b1;
      eff  = (pkt_size < MIN_SIZE) ? int'(MIN_SIZE) : int'(pkt_size);
      if (!in_pkt) begin
        if (b == SYNC_VAL) begin
          in_pkt    = 1'b1;
          idx       = '0;
          hdr       = '0;
          start_pos = here;
        end
        return;
      end
      idx = idx + 1'b1;
      if (idx >= HDR_FIRST && idx <= HDR_LAST) hdr = {hdr[15:0], b};
      if (int'(idx) + 1 < eff) return;
      in_pkt = 1'b0;
      id = {hdr[20:16], hdr[15:8]};
      if (id_count[id] != '1) id_count[id] = id_count[id] + 1'b1;
      r.packet_offset   = start_pos;
      r.error_flag      = hdr[23];
      r.unit_start      = hdr[22];
      r.priority_flag   = hdr[21];
      r.stream_id       = id;
      r.scrambling      = hdr[7:6];
      r.adaptation_mode = hdr[5:4];
      r.continuity      = hdr[3:0];
      r.id_packet_count = id_count[id];
      header_q.insert(header_q.size(), r);
    endfunction

    function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(hdr_result_t got);
      hdr_result_t e;
      if (header_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none actual offset %0h id %0h",
                   $time, got.packet_offset, got.stream_id);
        return;
      end
      e = header_q.pop_front();
      checked++;
      cmp_field("packet_offset", e.packet_offset, got.packet_offset);
      cmp_field("error_flag", e.error_flag, got.error_flag);
      cmp_field("unit_start", e.unit_start, got.unit_start);
      cmp_field("priority_flag", e.priority_flag, got.priority_flag);
      cmp_field("stream_id", e.stream_id, got.stream_id);
      cmp_field("scrambling", e.scrambling, got.scrambling);
      cmp_field("adaptation_mode", e.adaptation_mode, got.adaptation_mode);
      cmp_field("continuity", e.continuity, got.continuity);
      cmp_field("id_packet_count", e.id_packet_count, got.id_packet_count);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  tsp_in_if  in_ch ();
  tsp_out_if out_ch ();

  header_scoreboard sb = new();

  bit in_taken;
  bit idle_on;
  int out_stall;
  int quiet_cycles;
  int bytes_sent;
  int size_writes;

  ts_packet_header_parser_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    hdr_result_t got;
    in_taken = in_ch.valid && in_ch.ready;
    if (rst_n && in_taken) sb.note_byte(in_ch.data_byte);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.packet_offset   = out_ch.packet_offset;
      got.error_flag      = out_ch.error_flag;
      got.unit_start      = out_ch.unit_start;
      got.priority_flag   = out_ch.priority_flag;
      got.stream_id       = out_ch.stream_id;
      got.scrambling      = out_ch.scrambling;
      got.adaptation_mode = out_ch.adaptation_mode;
      got.continuity      = out_ch.continuity;
      got.id_packet_count = out_ch.id_packet_count;
      sb.check_result(got);
    end
    if (in_taken || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
      $display("tb: errors");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall = $urandom_range(1, 18) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
    bytes_sent++;
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_size(v);
    size_writes++;
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    unique case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ID_LAST;
      2, 3:    return 13'h0011;
      4, 5:    return 13'h1abc;
      6:       return 13'h0100;
      default: return ID_W'($urandom_range(0, ID_COUNT - 1));
    endcase
  endfunction

  task automatic send_packet(input int eff);
    logic [ID_W-1:0] id;
    logic [7:0]      b;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom_range(0, 255));
        if (b == SYNC_VAL) b = b ^ 8'h01;
        send_byte(b);
      end
    end
    id = pick_id();
    send_byte(SYNC_VAL);
    send_byte({3'($urandom_range(0, 7)), id[12:8]});
    send_byte(id[7:0]);
    send_byte(8'($urandom_range(0, 255)));
    repeat (eff - 4) send_byte(8'($urandom_range(0, 255)));
  endtask

  // loose bytes, or a sync followed by a cut-short packet
  task automatic send_garbage(input int eff);
    if ($urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(SYNC_VAL);
      repeat ($urandom_range(0, eff - 2)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [7:0]        seq[$];
    logic [SIZE_W-1:0] sz;
    int                eff;
    int                ph;
    int                npk;
    int                rand_start;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    idle_on         = 1'b1;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // noise, then a packet opened under the reset size and cut by a smaller size
    seq = '{8'h00, 8'hff, 8'h46, 8'h48, SYNC_VAL, 8'hff, 8'hff, 8'hff,
            SYNC_VAL, 8'h00, 8'h55, 8'haa, 8'h80, 8'h7f};
    foreach (seq[i]) send_byte(seq[i]);
    set_size(10'd8);
    send_byte(SYNC_VAL);

    // size below the header length, back to back packets
    set_size(10'd0);
    seq = '{SYNC_VAL, 8'h00, 8'h00, 8'h00, SYNC_VAL, 8'h1f, 8'hff, 8'hf0,
            SYNC_VAL, 8'ha0, 8'h00, 8'h5a, SYNC_VAL, 8'h40, 8'h01, 8'h81};
    foreach (seq[i]) send_byte(seq[i]);

    rand_start = bytes_sent;
    ph = 0;
    while (bytes_sent - rand_start < RANDOM_ITEMS) begin
      sz = (ph < 16) ? PHASE_SIZES[ph] : SIZE_W'($urandom_range(0, 40));
      set_size(sz);
      eff = (sz < MIN_SIZE) ? int'(MIN_SIZE) : int'(sz);
      if (bytes_sent - rand_start >= 1150) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      npk = (eff > 100) ? 1 : $urandom_range(3, 6);
      repeat (npk) begin
        if ($urandom_range(0, 7) == 0) send_garbage(eff);
        else send_packet(eff);
      end
      ph++;
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.pending() != 0)
      $display("%0t: %0d results never arrived", $time, sb.pending());
    $display("summary: %0d stream bytes, %0d headers checked, %0d packet size writes",
             bytes_sent, sb.checked, size_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
